>>> sv/circular_queue_fifo_core_assert.svh
// Assertion macros used by the circular queue FIFO back end.
`ifndef CIRCULAR_QUEUE_FIFO_CORE_ASSERT_SVH
`define CIRCULAR_QUEUE_FIFO_CORE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CQF_CHECK(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a consequence holds in the same cycle as its trigger.
`define CQF_CHECK_IMPL(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/cqf_pkg.sv
// Shared types, constants and helpers of the circular queue FIFO.
package cqf_pkg;

	localparam int DEPTH = 8;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// Command queue between the front and the back.
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = 1;
	localparam int CQ_CNT_W = 2;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_DELETE  = 2'd1;
	localparam logic [1:0] OP_DISPLAY = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		begin
			if (p == PTR_W'(DEPTH - 1)) begin
				n = '0;
			end else begin
				n = p + PTR_W'(1);
			end
			return n;
		end
	endfunction

endpackage

>>> sv/cqf_ifs.sv
// Valid/ready channel interfaces for the request and response words.
interface cqf_in_if;
	import cqf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               func;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface cqf_out_if;
	import cqf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data;
	logic                     last;

	modport source (output valid, output status, output data, output last, input ready);
	modport sink (input valid, input status, input data, input last, output ready);
endinterface

>>> sv/cqf_front.sv
// Request front end: decodes operations and queues them for the back end.
module cqf_front (
	input  logic          clk,
	input  logic          arst_n,
	cqf_in_if.sink        req,
	output logic          cmd_valid,
	output cqf_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import cqf_pkg::*;

	cmd_t                slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_q;
	logic [CQ_PTR_W-1:0] rd_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                take;
	logic                push;
	logic                pop;

	assign req.ready = (cnt_q != CQ_CNT_W'(CQ_DEPTH));
	assign take      = req.valid && req.ready;
	// An unused operation code is accepted and dropped; it causes no word.
	assign push      = take && (req.func != OP_UNUSED);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_q];
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{op: req.func, value: req.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + CQ_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + CQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CQ_CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/cqf_back.sv
// Back end: ring buffer storage, pointers and the registered response word.
`include "circular_queue_fifo_core_assert.svh"

module cqf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cqf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	cqf_out_if.source     rsp
);
	import cqf_pkg::*;

	localparam logic BK_RUN  = 1'b0;
	localparam logic BK_SHOW = 1'b1;

	logic signed [WORD_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]         head_q;
	logic [PTR_W-1:0]         tail_q;
	logic [CNT_W-1:0]         occ_q;
	logic                     state_q;
	logic [PTR_W-1:0]         disp_ptr_q;
	logic [CNT_W-1:0]         disp_idx_q;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [WORD_W-1:0] data_q;
	logic                     last_q;

	logic                     out_free;
	logic                     step;
	logic                     full;
	logic                     empty;
	logic [PTR_W-1:0]         rd_addr;
	logic [CNT_W-1:0]         cur_idx;
	logic                     disp_last;

	logic                     do_write;
	logic                     do_read;
	logic                     pop_c;
	logic                     state_d;
	logic [1:0]               status_d;
	logic                     take_word;
	logic                     last_d;

	assign out_free  = !out_valid_q || rsp.ready;
	assign step      = cmd_valid && out_free;
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign empty     = (occ_q == '0);
	assign rd_addr   = (state_q == BK_SHOW) ? disp_ptr_q : head_q;
	assign cur_idx   = (state_q == BK_SHOW) ? disp_idx_q : '0;
	assign disp_last = ((cur_idx + CNT_W'(1)) == occ_q);

	always_comb begin
		do_write  = 1'b0;
		do_read   = 1'b0;
		pop_c     = 1'b0;
		state_d   = state_q;
		status_d  = STS_OK;
		take_word = 1'b0;
		last_d    = 1'b1;
		if (step) begin
			case (cmd.op)
				OP_INSERT: begin
					pop_c = 1'b1;
					if (full) begin
						status_d = STS_FULL;
					end else begin
						do_write = 1'b1;
					end
				end
				OP_DELETE: begin
					pop_c = 1'b1;
					if (empty) begin
						status_d = STS_EMPTY;
					end else begin
						do_read   = 1'b1;
						take_word = 1'b1;
					end
				end
				OP_DISPLAY: begin
					if (empty) begin
						pop_c    = 1'b1;
						status_d = STS_EMPTY;
					end else begin
						take_word = 1'b1;
						last_d    = disp_last;
						if (disp_last) begin
							pop_c   = 1'b1;
							state_d = BK_RUN;
						end else begin
							state_d = BK_SHOW;
						end
					end
				end
				default: begin
					pop_c = 1'b1;
				end
			endcase
		end
	end

	assign cmd_pop = pop_c;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[tail_q] <= cmd.value;
		end
		if (step) begin
			status_q <= status_d;
			data_q   <= take_word ? mem_q[rd_addr] : '0;
			last_q   <= last_d;
		end
		if (step && (cmd.op == OP_DISPLAY)) begin
			disp_ptr_q <= next_ptr(rd_addr);
			disp_idx_q <= cur_idx + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			state_q     <= BK_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_write) begin
				tail_q <= next_ptr(tail_q);
				occ_q  <= occ_q + CNT_W'(1);
			end
			if (do_read) begin
				head_q <= next_ptr(head_q);
				occ_q  <= occ_q - CNT_W'(1);
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.data   = data_q;
	assign rsp.last   = last_q;

	`CQF_CHECK(a_occ_bound, occ_q <= CNT_W'(DEPTH), "occupancy exceeds depth")
	`CQF_CHECK_IMPL(a_empty_ptrs, occ_q == '0,
		head_q == tail_q, "empty queue with split pointers")
	`CQF_CHECK_IMPL(a_show_ctx, state_q == BK_SHOW,
		cmd_valid && (cmd.op == OP_DISPLAY) && (disp_idx_q < occ_q), "display walk lost its command")
	`CQF_CHECK_IMPL(a_no_rmw, do_write, !do_read, "write and read in one step")

endmodule

>>> sv/circular_queue_fifo_core.sv
// An accepted word enters the command queue, then the back end registers its response word.
// Insert and delete give one response word each; display gives one per stored word, or one.
// The back end retires a word per cycle unless rsp stalls; a two-word queue decouples input.
// Reset clears the pointers, occupancy, command queue and output valid, not the storage.
// A slot is read only after it has been written, so no clearing pass is run.
module circular_queue_fifo_core (
	input logic       clk,
	input logic       arst_n,
	cqf_in_if.sink    req,
	cqf_out_if.source rsp
);
	import cqf_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	cqf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	cqf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule
